FILE: rtl/lzwse_pkg.sv
// shared types and constants of the lzw stream encoder
package lzwse_pkg;

	localparam int LIT_CODES = 256;
	localparam int CODE_OUT_W = 11;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_HEAD = 5'b00010,
		S_WALK = 5'b00100,
		S_MISS = 5'b01000,
		S_LAST = 5'b10000
	} state_t;

	typedef struct packed {
		logic accept;     // latch the input word
		logic first;      // byte opens a new string
		logic step_head;  // fetch the entry named by the child head
		logic step_walk;  // fetch the next sibling
		logic hit;        // extension known, follow it
		logic miss;       // emit current code, learn, restart
		logic nolink;     // new entry has no older sibling
		logic last;       // emit final code and clear
	} cmd_t;

	typedef struct packed {
		logic active;
		logic eos;
		logic head_cand;
		logic prefix_ok;
		logic byte_ok;
		logic next_zero;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/lzw_stream_encoder.sv
// top level of the lzw stream encoder
//  channel | direction | handshake           | payload
//  in      | input     | in_valid, in_stall   | data_byte, end_of_stream
//  out     | output    | out_valid, out_stall | code, last_code
// a word is latched in idle and looked up in the head state, where the first
// byte of a stream ends; a hit ends in the walk state after k sibling steps and a
// miss goes to the miss state, from head with no child to check or from walk
// after k sibling steps; k is bounded by the children of the current code in the
// sibling chain, one entry memory read per step. an end-of-stream word then
// passes the last state, which emits the final code. reset is asynchronous; the
// dictionary memories are not cleared, stale entries are rejected by code range
// and prefix checks. a stalled output holds the controller in its emit state.
module lzw_stream_encoder #(
	parameter int DICT_SIZE = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [10:0] code,
	output logic        last_code,
	output logic        out_valid,
	input  logic        out_stall
);
	import lzwse_pkg::*;

	localparam int CW = $clog2(DICT_SIZE);

	cmd_t          cmd;
	sts_t          sts;
	logic [CW:0]   nf;
	logic [CW-1:0] ptr;

	lzwse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzwse_dp #(
		.DICT_SIZE (DICT_SIZE),
		.CW        (CW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.out_stall     (out_stall),
		.sts           (sts),
		.code          (code),
		.last_code     (last_code),
		.out_valid     (out_valid),
		.nf            (nf),
		.ptr           (ptr)
	);

	a_nf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nf <= (CW+1)'(DICT_SIZE))
		else $error("next free code beyond dictionary");

	a_hit_learned: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit |-> ({1'b0, ptr} < nf))
		else $error("hit on an unlearned code");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.miss || cmd.last) |-> sts.out_free)
		else $error("emit into an occupied output register");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.last |=> (nf == (CW+1)'(LIT_CODES)) && !sts.active)
		else $error("stream end did not clear the dictionary state");

endmodule

FILE: rtl/lzwse_dp.sv
// datapath: dictionary memories, string registers and output register
module lzwse_dp #(
	parameter int DICT_SIZE = 2048,
	parameter int CW = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lzwse_pkg::cmd_t               cmd,
	input  logic [7:0]                    data_byte,
	input  logic                          end_of_stream,
	input  logic                          out_stall,
	output lzwse_pkg::sts_t               sts,
	output logic [lzwse_pkg::CODE_OUT_W-1:0] code,
	output logic                          last_code,
	output logic                          out_valid,
	output logic [CW:0]                   nf,
	output logic [CW-1:0]                 ptr
);
	import lzwse_pkg::*;

	localparam int EW = CW + 8 + CW;

	logic [EW-1:0] ent_mem [DICT_SIZE];
	logic [CW-1:0] head_mem [DICT_SIZE];

	logic [7:0]    byte_q;
	logic          eos_q;
	logic [CW-1:0] cur_q;
	logic          active_q;
	logic [CW:0]   nf_q;
	logic [CW-1:0] head_q;
	logic [CW-1:0] link_q;
	logic [EW-1:0] ent_q;
	logic [CW-1:0] ptr_q;
	logic          out_valid_q;
	logic [CODE_OUT_W-1:0] code_q;
	logic          last_q;

	logic [CW-1:0] ent_prefix;
	logic [7:0]    ent_byte;
	logic [CW-1:0] ent_next;
	logic [CW-1:0] rd_addr;
	logic [CW-1:0] link;
	logic          room;
	logic          learn;
	logic          out_free;
	logic          step;

	assign ent_prefix = ent_q[EW-1 -: CW];
	assign ent_byte   = ent_q[CW +: 8];
	assign ent_next   = ent_q[CW-1:0];
	assign rd_addr    = cmd.step_head ? head_q : ent_next;
	assign link       = cmd.nolink ? '0 : link_q;
	assign room       = nf_q < (CW+1)'(DICT_SIZE);
	assign learn      = cmd.miss && room;
	assign out_free   = !out_valid_q || !out_stall;
	assign step       = cmd.step_head || cmd.step_walk;

	// head of each prefix's child list, not cleared between streams
	always_ff @(posedge clk) begin
		head_q <= head_mem[cur_q];
		if (learn) begin
			head_mem[cur_q] <= nf_q[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ent_q <= ent_mem[rd_addr];
		end
		if (learn) begin
			ent_mem[nf_q[CW-1:0]] <= {cur_q, byte_q, link};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= data_byte;
			eos_q  <= end_of_stream;
		end
		if (step) begin
			ptr_q <= rd_addr;
		end
		if (cmd.step_head) begin
			link_q <= head_q;
		end
		if (cmd.miss) begin
			code_q <= CODE_OUT_W'(cur_q);
			last_q <= 1'b0;
		end else if (cmd.last) begin
			code_q <= CODE_OUT_W'(cur_q);
			last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			active_q    <= 1'b0;
			nf_q        <= (CW+1)'(LIT_CODES);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.miss || cmd.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (learn) begin
				nf_q <= nf_q + 1'b1;
			end
			if (cmd.first) begin
				cur_q    <= CW'(byte_q);
				active_q <= 1'b1;
			end else if (cmd.hit) begin
				cur_q <= ptr_q;
			end else if (cmd.miss) begin
				cur_q <= CW'(byte_q);
			end else if (cmd.last) begin
				cur_q    <= '0;
				active_q <= 1'b0;
				nf_q     <= (CW+1)'(LIT_CODES);
			end
		end
	end

	always_comb begin
		sts.active    = active_q;
		sts.eos       = eos_q;
		sts.head_cand = (head_q >= CW'(LIT_CODES)) && ({1'b0, head_q} < nf_q);
		sts.prefix_ok = ent_prefix == cur_q;
		sts.byte_ok   = ent_byte == byte_q;
		sts.next_zero = ent_next == '0;
		sts.out_free  = out_free;
	end

	assign code      = code_q;
	assign last_code = last_q;
	assign out_valid = out_valid_q;
	assign nf        = nf_q;
	assign ptr       = ptr_q;

endmodule

FILE: rtl/lzwse_ctrl.sv
// controller: per-word sequencing of lookup, learning and emission
module lzwse_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  lzwse_pkg::sts_t sts,
	output lzwse_pkg::cmd_t cmd
);
	import lzwse_pkg::*;

	state_t state_q, state_d;
	logic   nolink_q, nolink_d;

	always_comb begin
		state_d  = state_q;
		nolink_d = nolink_q;
		cmd      = '0;
		cmd.nolink = nolink_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_HEAD;
				end
			end
			S_HEAD: begin
				if (!sts.active) begin
					cmd.first = 1'b1;
					state_d   = sts.eos ? S_LAST : S_IDLE;
				end else if (sts.head_cand) begin
					cmd.step_head = 1'b1;
					state_d       = S_WALK;
				end else begin
					nolink_d = 1'b1;
					state_d  = S_MISS;
				end
			end
			S_WALK: begin
				// a stale head fails the prefix check
				if (!sts.prefix_ok) begin
					nolink_d = 1'b1;
					state_d  = S_MISS;
				end else if (sts.byte_ok) begin
					cmd.hit = 1'b1;
					state_d = sts.eos ? S_LAST : S_IDLE;
				end else if (sts.next_zero) begin
					nolink_d = 1'b0;
					state_d  = S_MISS;
				end else begin
					cmd.step_walk = 1'b1;
				end
			end
			S_MISS: begin
				if (sts.out_free) begin
					cmd.miss = 1'b1;
					state_d  = sts.eos ? S_LAST : S_IDLE;
				end
			end
			S_LAST: begin
				if (sts.out_free) begin
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			nolink_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			nolink_q <= nolink_d;
		end
	end

	assign in_stall = state_q != S_IDLE;

endmodule
